// ===== hw/rtl/bsr_pkg.sv =====
package bsr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 32;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} bsr_state_t;

endpackage

// ===== hw/rtl/bsr_ram.sv =====
module bsr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/byte_stream_reassembler.sv =====
// latency: an in-order byte gives its result in the cycle after its transaction
// held bytes that follow it come out one per cycle after that, busy stays high meanwhile
// throughput: one transaction per cycle while no drain runs; no transaction is taken during a drain
// each drained byte comes from the registered read of the byte store
// reset clears the expected index, the held count and the slot valid bits at once
// the receiver cannot stall: every result strobe lasts exactly one cycle
module byte_stream_reassembler
	import bsr_pkg::*;
#(
	parameter int unsigned WINDOW = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [BYTE_W-1:0]  byte_value,
	input  logic [INDEX_W-1:0] stream_index,
	input  logic               eof_here,
	output logic               result_valid,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               end_of_stream,
	output logic               last_of_run,
	output logic [COUNT_W-1:0] unassembled_count,
	output logic [INDEX_W-1:0] next_expected
);

	localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned DATA_W = BYTE_W + 1;

	bsr_state_t state_q, state_d;

	logic [INDEX_W-1:0] expected_q;
	logic [SLOT_W-1:0]  exp_slot_q;
	logic [COUNT_W-1:0] count_q;
	logic [WINDOW-1:0]  valid_q;

	logic               res_valid_q;
	logic [BYTE_W-1:0]  res_byte_q;
	logic               res_eof_q;
	logic               res_last_q;
	logic [COUNT_W-1:0] res_count_q;
	logic [INDEX_W-1:0] res_next_q;

	logic [INDEX_W:0]   diff;
	logic               in_win;
	logic               hit;
	logic [SLOT_W-1:0]  offset;
	logic [SLOT_W:0]    slot_sum;
	logic [SLOT_W-1:0]  in_slot;
	logic [SLOT_W-1:0]  nxt_slot;

	logic               ram_we;
	logic               ram_re;
	logic [SLOT_W-1:0]  ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;

	logic               advance;
	logic               res_load;
	logic [BYTE_W-1:0]  res_byte_d;
	logic               res_eof_d;
	logic               res_last_d;
	logic [COUNT_W-1:0] count_d;
	logic               set_valid;
	logic               clr_valid;

	// offset of the incoming byte from the expected index, no wrap
	assign diff     = {1'b0, stream_index} - {1'b0, expected_q};
	assign in_win   = !diff[INDEX_W] && (diff[INDEX_W-1:0] < INDEX_W'(WINDOW));
	assign hit      = (diff[INDEX_W-1:0] == '0);
	assign offset   = diff[SLOT_W-1:0];
	assign slot_sum = {1'b0, exp_slot_q} + {1'b0, offset};
	assign in_slot  = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
		SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : slot_sum[SLOT_W-1:0];

	// slot of the index after the expected one, index wrap returns to slot zero
	assign nxt_slot = ((expected_q == '1) || (exp_slot_q == SLOT_W'(WINDOW - 1))) ?
		'0 : exp_slot_q + 1'b1;

	bsr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_slot),
		.wdata ({eof_here, byte_value}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		advance    = 1'b0;
		res_load   = 1'b0;
		res_byte_d = byte_value;
		res_eof_d  = eof_here;
		res_last_d = !valid_q[nxt_slot];
		count_d    = count_q;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = nxt_slot;
		case (state_q)
			ST_IDLE: begin
				if (start && in_win) begin
					if (hit) begin
						advance  = 1'b1;
						res_load = 1'b1;
						if (valid_q[nxt_slot]) begin
							ram_re  = 1'b1;
							state_d = ST_DRAIN;
						end
					end else if (!valid_q[in_slot]) begin
						ram_we    = 1'b1;
						set_valid = 1'b1;
						count_d   = count_q + 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				advance    = 1'b1;
				res_load   = 1'b1;
				res_byte_d = ram_rdata[BYTE_W-1:0];
				res_eof_d  = ram_rdata[BYTE_W];
				clr_valid  = 1'b1;
				count_d    = count_q - 1'b1;
				if (valid_q[nxt_slot]) begin
					ram_re = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q  <= '0;
			exp_slot_q  <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_load;
			count_q     <= count_d;
			if (advance) begin
				expected_q <= expected_q + 1'b1;
				exp_slot_q <= nxt_slot;
			end
			if (set_valid) begin
				valid_q[in_slot] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[exp_slot_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_byte_q  <= res_byte_d;
			res_eof_q   <= res_eof_d;
			res_last_q  <= res_last_d;
			res_count_q <= count_d;
			res_next_q  <= expected_q + 1'b1;
		end
	end

	assign busy              = (state_q == ST_DRAIN);
	assign result_valid      = res_valid_q;
	assign out_byte          = res_byte_q;
	assign end_of_stream     = res_eof_q;
	assign last_of_run       = res_last_q;
	assign unassembled_count = res_count_q;
	assign next_expected     = res_next_q;

endmodule

// ===== verif/byte_stream_reassembler_tb.sv =====
module byte_stream_reassembler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsr_pkg::*;

	localparam int WIN = 64;
	localparam int unsigned LIMIT = 200000;

	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               eos;
		logic               last;
		logic [COUNT_W-1:0] count;
		logic [INDEX_W-1:0] next;
	} delivery_t;

	class reassembly_tracker;
		bit [INDEX_W-1:0] exp_idx;
		bit [BYTE_W-1:0]  slot_byte [WIN];
		bit               slot_full [WIN];
		bit               slot_eof [WIN];
		int unsigned      held;
		delivery_t        due [$];
		int unsigned      failures;
		int unsigned      delivered;
		int unsigned      dropped;
		int unsigned      stored;
		int unsigned      longest;

		function void take_byte(input bit [BYTE_W-1:0] b, input bit [INDEX_W-1:0] idx,
				input bit eof);
			bit [INDEX_W-1:0] offset;
			int slot;
			int n;
			delivery_t cur;
			offset = idx - exp_idx;
			if (idx < exp_idx || offset >= WIN) begin
				dropped++;
				return;
			end
			// ahead of the gap: keep the first copy only
			if (offset != 0) begin
				slot = int'(idx % WIN);
				if (!slot_full[slot]) begin
					slot_full[slot] = 1'b1;
					slot_byte[slot] = b;
					slot_eof[slot] = eof;
					held++;
					stored++;
				end else begin
					dropped++;
				end
				return;
			end
			exp_idx++;
			cur = '{data: b, eos: eof, last: 1'b0, count: COUNT_W'(held), next: exp_idx};
			n = 1;
			forever begin
				slot = int'(exp_idx % WIN);
				if (!slot_full[slot] || n >= WIN)
					break;
				due.push_back(cur);
				slot_full[slot] = 1'b0;
				if (held > 0)
					held--;
				exp_idx++;
				cur = '{data: slot_byte[slot], eos: slot_eof[slot], last: 1'b0,
					count: COUNT_W'(held), next: exp_idx};
				n++;
			end
			cur.last = 1'b1;
			due.push_back(cur);
			if (n > longest)
				longest = n;
		endfunction

		function void match_delivery(input delivery_t seen);
			delivery_t want;
			if (due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: byte %02h eos %0b last %0b count %0d next %0d",
						seen.data, seen.eos, seen.last, seen.count, seen.next);
				return;
			end
			want = due.pop_front();
			delivered++;
			if (seen !== want) begin
				failures++;
				if (failures <= 10) begin
					$display("mismatch: expected byte %02h eos %0b last %0b count %0d next %0d",
						want.data, want.eos, want.last, want.count, want.next);
					$display("          got      byte %02h eos %0b last %0b count %0d next %0d",
						seen.data, seen.eos, seen.last, seen.count, seen.next);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [BYTE_W-1:0]  byte_value;
	logic [INDEX_W-1:0] stream_index;
	logic               eof_here;
	logic               result_valid;
	logic [BYTE_W-1:0]  out_byte;
	logic               end_of_stream;
	logic               last_of_run;
	logic [COUNT_W-1:0] unassembled_count;
	logic [INDEX_W-1:0] next_expected;

	reassembly_tracker trk;
	int unsigned burst_left = 0;
	int unsigned sent = 0;
	int unsigned cycles = 0;

	byte_stream_reassembler #(
		.WINDOW(WIN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.byte_value(byte_value),
		.stream_index(stream_index),
		.eof_here(eof_here),
		.result_valid(result_valid),
		.out_byte(out_byte),
		.end_of_stream(end_of_stream),
		.last_of_run(last_of_run),
		.unassembled_count(unassembled_count),
		.next_expected(next_expected)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// transactions and results both sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				trk.take_byte(byte_value, stream_index, eof_here);
			if (result_valid)
				trk.match_delivery(delivery_t'{out_byte, end_of_stream, last_of_run,
					unassembled_count, next_expected});
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic [INDEX_W-1:0] idx,
			input logic eof);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		start <= 1'b1;
		byte_value <= b;
		stream_index <= idx;
		eof_here <= eof;
		do @(posedge clk); while (busy);
		burst_left--;
		sent++;
	endtask

	task automatic push_noise(input int unsigned fill_base);
		case ($urandom_range(0, 2))
			0: push_byte(BYTE_W'($urandom_range(0, 255)),
				(fill_base > 0) ? $urandom_range(0, fill_base - 1) : $urandom,
				1'($urandom_range(0, 1)));
			1: push_byte(BYTE_W'($urandom_range(0, 255)),
				fill_base + 128 + $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
			default: push_byte(BYTE_W'($urandom_range(0, 255)), $urandom,
				1'($urandom_range(0, 1)));
		endcase
	endtask

	initial begin
		int unsigned fill_base;
		int unsigned seg_len;
		int unsigned seg_items;
		int unsigned mode;
		int unsigned k;
		int unsigned j;
		bit [INDEX_W-1:0] order [$];
		bit [INDEX_W-1:0] tmp;

		trk = new();
		arst_n = 1'b0;
		start = 1'b0;
		byte_value = '0;
		stream_index = '0;
		eof_here = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: stale, window edges, duplicates, eof marks, short drain
		push_byte(8'h00, 32'd0, 1'b0);
		push_byte(8'h11, 32'd0, 1'b0);
		push_byte(8'h22, 32'd65, 1'b0);
		push_byte(8'hFF, 32'd64, 1'b1);
		push_byte(8'h5A, 32'd64, 1'b0);
		push_byte(8'h33, 32'hFFFF_FFFF, 1'b1);
		push_byte(8'h44, 32'h8000_0000, 1'b0);
		push_byte(8'hA5, 32'd2, 1'b0);
		push_byte(8'h3C, 32'd3, 1'b1);
		push_byte(8'h80, 32'd1, 1'b0);
		push_byte(8'h7F, 32'd4, 1'b1);
		push_byte(8'hFF, 32'd5, 1'b0);
		push_byte(8'h01, 32'd5, 1'b1);
		push_byte(8'hC3, 32'd6 + 32'd64, 1'b0);

		// random segments, the first one fills the whole window before its head
		fill_base = 6;
		seg_items = 0;
		while (seg_items < 72) begin
			if (seg_items == 0) begin
				seg_len = WIN;
				mode = 2;
			end else begin
				seg_len = ($urandom_range(0, 5) == 0) ? $urandom_range(33, WIN) :
					$urandom_range(1, 16);
				mode = $urandom_range(0, 2);
			end
			order.delete();
			for (k = 0; k < seg_len; k++)
				order.push_back(fill_base + k);
			if (mode == 1) begin
				for (k = seg_len - 1; k > 0; k--) begin
					j = $urandom_range(0, k);
					tmp = order[k];
					order[k] = order[j];
					order[j] = tmp;
				end
			end else if (mode == 2) begin
				// head of the segment last: longest drain
				tmp = order.pop_front();
				order.push_back(tmp);
			end
			foreach (order[k]) begin
				if ($urandom_range(0, 7) == 0)
					push_noise(fill_base);
				push_byte(BYTE_W'($urandom_range(0, 255)), order[k],
					(order[k] == fill_base + seg_len - 1) ? 1'($urandom_range(0, 1)) :
					($urandom_range(0, 15) == 0));
				if ($urandom_range(0, 7) == 0)
					push_byte(BYTE_W'($urandom_range(0, 255)), order[k],
						1'($urandom_range(0, 1)));
			end
			seg_items += seg_len;
			fill_base += seg_len;
		end
		start <= 1'b0;

		while (trk.due.size() != 0)
			@(posedge clk);
		repeat (WIN + 8) @(posedge clk);
		if (trk.due.size() != 0) begin
			trk.failures += trk.due.size();
			$display("%0d expected results never arrived", trk.due.size());
		end

		$display("%0d transactions sent, %0d held out of order, %0d dropped",
			sent, trk.stored, trk.dropped);
		$display("%0d delivered bytes checked, longest drain %0d bytes, %0d failures",
			trk.delivered, trk.longest, trk.failures);
		if (trk.failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/bsr_pkg.sv
hw/rtl/bsr_ram.sv
hw/rtl/byte_stream_reassembler.sv
verif/byte_stream_reassembler_tb.sv
